[design/sp_pkg.sv]
// ----------------------------------------------------------------------------
// sp_pkg
// Shared types and constants of the polled telemetry receive parser.
// ----------------------------------------------------------------------------
package sp_pkg;

  localparam int unsigned PayloadLen = 7;
  localparam int unsigned SumWidth   = 11;
  localparam logic [7:0]  SumTarget  = 8'hFF;

  // register reset values
  localparam logic [7:0] StartByteRst   = 8'd126;
  localparam logic [7:0] OwnIdRst       = 8'd27;
  localparam logic [7:0] HostIdRst      = 8'd13;
  localparam logic [7:0] EscapeByteRst  = 8'd125;
  localparam logic [7:0] EscapeMaskRst  = 8'd32;
  localparam logic       CheckEnableRst = 1'b1;

  typedef enum logic [2:0] {
    REG_START_BYTE   = 3'd0,
    REG_OWN_ID       = 3'd1,
    REG_HOST_ID      = 3'd2,
    REG_ESCAPE_BYTE  = 3'd3,
    REG_ESCAPE_MASK  = 3'd4,
    REG_CHECK_ENABLE = 3'd5
  } sp_reg_e;

  typedef enum logic [1:0] {
    CTS_KEEP  = 2'd0,
    CTS_CLEAR = 2'd1,
    CTS_GRANT = 2'd2
  } sp_cts_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] own_sensor_id;
    logic [7:0] host_sensor_id;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
    logic       check_enable;
  } sp_cfg_t;

  typedef struct packed {
    sp_cts_e     cts_action;
    logic        frame_valid;
    logic [7:0]  frame_type;
    logic [15:0] value_id;
    logic [31:0] value_data;
  } sp_result_t;

endpackage

[design/sp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sp_cfg_regs
// Configuration register file behind the register access port.
// ----------------------------------------------------------------------------
module sp_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output sp_pkg::sp_cfg_t cfg_o
);
  import sp_pkg::*;

  sp_cfg_t cfg_q, cfg_d;
  logic    wr_en;
  sp_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = sp_reg_e'(paddr[4:2]);
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_START_BYTE:   cfg_d.start_byte     = pwdata[7:0];
        REG_OWN_ID:       cfg_d.own_sensor_id  = pwdata[7:0];
        REG_HOST_ID:      cfg_d.host_sensor_id = pwdata[7:0];
        REG_ESCAPE_BYTE:  cfg_d.escape_byte    = pwdata[7:0];
        REG_ESCAPE_MASK:  cfg_d.escape_mask    = pwdata[7:0];
        REG_CHECK_ENABLE: cfg_d.check_enable   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_BYTE:   prdata = {24'd0, cfg_q.start_byte};
      REG_OWN_ID:       prdata = {24'd0, cfg_q.own_sensor_id};
      REG_HOST_ID:      prdata = {24'd0, cfg_q.host_sensor_id};
      REG_ESCAPE_BYTE:  prdata = {24'd0, cfg_q.escape_byte};
      REG_ESCAPE_MASK:  prdata = {24'd0, cfg_q.escape_mask};
      REG_CHECK_ENABLE: prdata = {31'd0, cfg_q.check_enable};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte     <= StartByteRst;
      cfg_q.own_sensor_id  <= OwnIdRst;
      cfg_q.host_sensor_id <= HostIdRst;
      cfg_q.escape_byte    <= EscapeByteRst;
      cfg_q.escape_mask    <= EscapeMaskRst;
      cfg_q.check_enable   <= CheckEnableRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/sp_parse_core.sv]
// ----------------------------------------------------------------------------
// sp_parse_core
// Input register, per-byte parse state update and result register.
// ----------------------------------------------------------------------------
module sp_parse_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sp_pkg::sp_cfg_t    cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               more_pending_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sp_pkg::sp_result_t result_o
);
  import sp_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_more_q;

  // parse state
  logic                hunting_q, hunting_d;
  logic                expect_q, expect_d;
  logic                esc_q, esc_d;
  logic [2:0]          count_q, count_d;
  logic [SumWidth-1:0] sum_q, sum_d;
  logic [7:0]          store_q [PayloadLen];
  logic [7:0]          store_d [PayloadLen];

  // result register
  logic       out_valid_q;
  sp_result_t result_q, result_d;

  logic                fire;
  logic [7:0]          data_b;
  logic [SumWidth-1:0] sum_add;
  logic [8:0]          sum_fold;
  logic                emit;
  sp_cts_e             cts_d;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  assign data_b   = in_byte_q ^ (esc_q ? cfg_i.escape_mask : 8'h00);
  assign sum_add  = sum_q + {3'd0, data_b};
  assign sum_fold = {1'b0, sum_add[7:0]} + {6'd0, sum_add[10:8]};

  always_comb begin
    hunting_d = hunting_q;
    expect_d  = expect_q;
    esc_d     = esc_q;
    count_d   = count_q;
    sum_d     = sum_q;
    store_d   = store_q;
    cts_d     = CTS_KEEP;
    emit      = 1'b0;
    if (fire) begin
      if (in_byte_q == cfg_i.start_byte) begin
        // start byte wins always, a pending escape carries over
        cts_d     = CTS_CLEAR;
        count_d   = 3'd0;
        expect_d  = 1'b1;
        hunting_d = 1'b0;
      end else if (hunting_q) begin
        hunting_d = 1'b1;
      end else if (expect_q) begin
        expect_d = 1'b0;
        if (in_byte_q == cfg_i.own_sensor_id && !in_more_q) begin
          cts_d     = CTS_GRANT;
          hunting_d = 1'b1;
        end else if (in_byte_q == cfg_i.host_sensor_id) begin
          sum_d = '0;
        end else begin
          hunting_d = 1'b1;
        end
      end else if (in_byte_q == cfg_i.escape_byte) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (count_q != 3'(PayloadLen)) begin
          store_d[count_q] = data_b;
          count_d          = count_q + 3'd1;
          sum_d            = sum_add;
          if (!cfg_i.check_enable && count_q == 3'(PayloadLen - 1)) begin
            hunting_d = 1'b1;
            emit      = 1'b1;
          end
        end else begin
          // checksum byte: fold once end-around
          hunting_d = 1'b1;
          sum_d     = {2'd0, sum_fold};
          emit      = (sum_fold == {1'b0, SumTarget});
        end
      end
    end
  end

  always_comb begin
    result_d.cts_action  = cts_d;
    result_d.frame_valid = emit;
    result_d.frame_type  = emit ? store_d[0] : 8'd0;
    result_d.value_id    = emit ? {store_d[2], store_d[1]} : 16'd0;
    result_d.value_data  = emit ? {store_d[6], store_d[5], store_d[4], store_d[3]} : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hunting_q   <= 1'b1;
      expect_q    <= 1'b0;
      esc_q       <= 1'b0;
      count_q     <= 3'd0;
      sum_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      hunting_q <= hunting_d;
      expect_q  <= expect_d;
      esc_q     <= esc_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
      in_more_q <= more_pending_i;
    end
    if (fire) begin
      result_q <= result_d;
    end
    store_q <= store_d;
  end

  a_state_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hunting_q && expect_q))
    else $error("hunting and expecting id at once");

  a_emit_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && emit |=> hunting_q)
    else $error("frame presented without returning to hunt");

  a_grant_hunts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cts_d == CTS_GRANT |=> hunting_q && !expect_q)
    else $error("grant without returning to hunt");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.frame_valid |->
      result_q.frame_type == 8'd0 && result_q.value_id == 16'd0 &&
      result_q.value_data == 32'd0)
    else $error("payload fields set without a frame");

  a_frame_no_cts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_q.frame_valid |-> result_q.cts_action == CTS_KEEP)
    else $error("frame and clear-to-send change in one result");

endmodule

[design/smartport_poll_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// smartport_poll_frame_parser_unit
// Receive parser for a polled half-duplex telemetry bus.
// ----------------------------------------------------------------------------
// Each received byte request on the slave stream yields exactly one result
// request on the master stream, in order. The block takes one byte per clock
// cycle while the master stream accepts results. Each byte is taken into the
// input register; the parse state update writes its result into the result
// register when that is free. The result register decouples the sides, so
// one more byte is taken into the input register while the previous result
// waits, after which the input stalls. Registers sit at byte addresses 0x00
// to 0x14 and should be written only while the stream is idle.
module smartport_poll_frame_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // register access port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] more_pending, rest zero
  // parse results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] frame_type, [23:8] value_id,
                                      // [55:24] value_data
  output logic [2:0]  m_axis_tuser    // [1:0] cts_action, [2] frame_valid
);
  import sp_pkg::*;

  sp_cfg_t    cfg;
  sp_result_t result;

  sp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sp_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .rx_byte_i      (s_axis_tdata[7:0]),
    .more_pending_i (s_axis_tdata[8]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (result)
  );

  assign m_axis_tdata = {result.value_data, result.value_id, result.frame_type};
  assign m_axis_tuser = {result.frame_valid, result.cts_action};

endmodule

[tb/tb_smartport_poll_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// tb_smartport_poll_frame_parser_unit
// Self-checking bench for the polled telemetry receive parser. Bytes go in on
// the slave stream and the bench predicts each result request from its own
// copy of the parse state and register settings. Every result on the master
// stream is checked field by field. Directed frames and polls come first,
// then a receiver hold-off that fills the block, then random traffic under
// several register settings with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_smartport_poll_frame_parser_unit;
  import sp_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [7:0] rx_byte, [8] more_pending, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // [7:0] frame_type, [23:8] value_id,
                                     // [55:24] value_data
  logic [2:0]  m_axis_tuser;         // [1:0] cts_action, [2] frame_valid

  smartport_poll_frame_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // bench copy of the registers and the parse state
  sp_cfg_t     cfg = '{start_byte: StartByteRst, own_sensor_id: OwnIdRst,
                       host_sensor_id: HostIdRst, escape_byte: EscapeByteRst,
                       escape_mask: EscapeMaskRst, check_enable: CheckEnableRst};
  logic [7:0]  pl_store [PayloadLen];
  logic [2:0]  pl_count  = '0;
  logic        hunting   = 1'b1;
  logic        id_next   = 1'b0;
  logic        esc_pend  = 1'b0;
  logic [10:0] sum_acc   = '0;

  sp_result_t  parse_results_q [$];
  logic [8:0]  wire_q [$];            // {more_pending, rx_byte}

  int unsigned mismatches = 0;
  int unsigned n_results  = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned rx_wait    = 0;
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  logic        hold_off   = 1'b0;

  // ---------------------------------------------------------------- predictor
  task automatic predict_parse(input logic [7:0] rx, input logic more);
    sp_result_t r;
    logic [7:0] b;
    r = '0;
    r.cts_action = CTS_KEEP;
    b = rx;
    if (b == cfg.start_byte) begin
      // a pending escape survives a restart on purpose
      r.cts_action = CTS_CLEAR;
      pl_count = '0;
      id_next  = 1'b1;
      hunting  = 1'b0;
    end else if (hunting) begin
      r.cts_action = CTS_KEEP;
    end else if (id_next) begin
      id_next = 1'b0;
      if (b == cfg.own_sensor_id && !more) begin
        r.cts_action = CTS_GRANT;
        hunting = 1'b1;
      end else if (b == cfg.host_sensor_id) begin
        sum_acc = '0;
      end else begin
        hunting = 1'b1;
      end
    end else if (b == cfg.escape_byte) begin
      esc_pend = 1'b1;
    end else begin
      if (esc_pend) begin
        b = b ^ cfg.escape_mask;
        esc_pend = 1'b0;
      end
      if (pl_count < PayloadLen) begin
        pl_store[pl_count] = b;
        pl_count = pl_count + 3'd1;
        sum_acc = sum_acc + {3'b000, b};
        if (!cfg.check_enable && pl_count == PayloadLen) begin
          hunting = 1'b1;
          r.frame_valid = 1'b1;
        end
      end else begin
        hunting = 1'b1;
        sum_acc = sum_acc + {3'b000, b};
        sum_acc = {3'b000, sum_acc[7:0]} + {8'h00, sum_acc[10:8]};
        if (sum_acc == {3'b000, SumTarget}) r.frame_valid = 1'b1;
      end
      if (r.frame_valid) begin
        r.frame_type = pl_store[0];
        r.value_id   = {pl_store[2], pl_store[1]};
        r.value_data = {pl_store[6], pl_store[5], pl_store[4], pl_store[3]};
      end
    end
    parse_results_q.push_back(r);
  endtask

  // ------------------------------------------------------------ byte builders
  function automatic logic [7:0] sum_byte_for(input logic [55:0] pl);
    logic [10:0] s;
    logic [10:0] t;
    s = '0;
    for (int i = 0; i < 7; i++) s = s + {3'b000, pl[8*i +: 8]};
    for (int c = 0; c < 256; c++) begin
      t = s + {3'b000, 8'(c)};
      t = {3'b000, t[7:0]} + {8'h00, t[10:8]};
      if (t == {3'b000, SumTarget}) return 8'(c);
    end
    return 8'h00;
  endfunction

  task automatic push_raw(input logic [7:0] b, input logic more);
    wire_q.push_back({more, b});
  endtask

  task automatic push_coded(input logic [7:0] b, input bit rnd);
    logic m;
    m = rnd ? 1'($urandom()) : 1'b1;
    if (b == cfg.start_byte || b == cfg.escape_byte ||
        (rnd && $urandom_range(0, 15) == 0)) begin
      push_raw(cfg.escape_byte, m);
      push_raw(b ^ cfg.escape_mask, m);
    end else begin
      push_raw(b, m);
    end
  endtask

  task automatic push_host_frame(input logic [55:0] pl, input bit good_sum, input bit rnd);
    logic [7:0] sum_b;
    push_raw(cfg.start_byte, 1'b1);
    push_raw(cfg.host_sensor_id, rnd ? 1'($urandom()) : 1'b1);
    for (int i = 0; i < 7; i++) begin
      if (rnd && $urandom_range(0, 29) == 0) begin
        // frame cut off right after an escape, next start restarts it
        push_raw(cfg.escape_byte, 1'b1);
        return;
      end
      push_coded(pl[8*i +: 8], rnd);
    end
    sum_b = good_sum ? sum_byte_for(pl) : 8'($urandom());
    if (cfg.check_enable || (rnd && $urandom_range(0, 1) == 0)) push_coded(sum_b, rnd);
  endtask

  task automatic make_burst();
    int unsigned pick;
    logic [55:0] pl;
    pick = $urandom_range(0, 99);
    pl[31:0]  = $urandom();
    pl[55:32] = 24'($urandom());
    if (pick < 55) begin
      push_host_frame(pl, $urandom_range(0, 9) != 0, 1'b1);
    end else if (pick < 70) begin
      push_raw(cfg.start_byte, 1'b1);
      push_raw(cfg.own_sensor_id, 1'($urandom()));
    end else if (pick < 80) begin
      push_raw(cfg.start_byte, 1'($urandom()));
      push_raw(8'($urandom()), 1'($urandom()));
    end else begin
      repeat ($urandom_range(1, 6)) push_raw(8'($urandom()), 1'($urandom()));
    end
  endtask

  // ------------------------------------------------------------------ drivers
  task automatic send_byte(input logic [7:0] b, input logic more);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, more, b};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_parse(b, more);
  endtask

  task automatic send_wire();
    logic [8:0] w;
    while (wire_q.size() != 0) begin
      w = wire_q.pop_front();
      send_byte(w[7:0], w[8]);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input sp_reg_e idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_START_BYTE:   cfg.start_byte     = v;
      REG_OWN_ID:       cfg.own_sensor_id  = v;
      REG_HOST_ID:      cfg.host_sensor_id = v;
      REG_ESCAPE_BYTE:  cfg.escape_byte    = v;
      REG_ESCAPE_MASK:  cfg.escape_mask    = v;
      REG_CHECK_ENABLE: cfg.check_enable   = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [7:0] own, input logic [7:0] host,
                            input logic [7:0] esc, input logic [7:0] mask, input logic chk);
    reg_write(REG_START_BYTE, sb);
    reg_write(REG_OWN_ID, own);
    reg_write(REG_HOST_ID, host);
    reg_write(REG_ESCAPE_BYTE, esc);
    reg_write(REG_ESCAPE_MASK, mask);
    reg_write(REG_CHECK_ENABLE, {7'b0, chk});
  endtask

  // ------------------------------------------------------------ result side
  always @(posedge clk_i) begin : rx_ready_gen
    int unsigned w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      w = rx_idle_en ? $urandom_range(0, 7) : 0;
      rx_wait <= w;
      m_axis_tready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on result %0d: %s", n_results, msg);
  endtask

  always @(posedge clk_i) begin : result_check
    sp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (parse_results_q.size() == 0) begin
        flag_mismatch("result with no byte request outstanding");
      end else begin
        want = parse_results_q.pop_front();
        if (m_axis_tuser[1:0] !== want.cts_action)
          flag_mismatch($sformatf("cts_action exp %0d got %0d",
                                  want.cts_action, m_axis_tuser[1:0]));
        if (m_axis_tuser[2] !== want.frame_valid)
          flag_mismatch($sformatf("frame_valid exp %0d got %0d",
                                  want.frame_valid, m_axis_tuser[2]));
        if (m_axis_tdata[7:0] !== want.frame_type)
          flag_mismatch($sformatf("frame_type exp %02h got %02h",
                                  want.frame_type, m_axis_tdata[7:0]));
        if (m_axis_tdata[23:8] !== want.value_id)
          flag_mismatch($sformatf("value_id exp %04h got %04h",
                                  want.value_id, m_axis_tdata[23:8]));
        if (m_axis_tdata[55:24] !== want.value_data)
          flag_mismatch($sformatf("value_data exp %08h got %08h",
                                  want.value_data, m_axis_tdata[55:24]));
      end
      n_results++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------- tests
  task automatic test_reset_frame_and_polls();
    // extremes plus both stuffed values in the payload, then both poll kinds
    push_host_frame({8'h55, 8'h80, 8'h01, 8'h7E, 8'h7D, 8'hFF, 8'h00}, 1'b1, 1'b0);
    push_raw(cfg.start_byte, 1'b1);
    push_raw(cfg.own_sensor_id, 1'b0);
    push_raw(cfg.start_byte, 1'b1);
    push_raw(cfg.own_sensor_id, 1'b1);
    send_wire();
    wait_idle();
  endtask

  task automatic test_no_check_frame();
    reg_write(REG_CHECK_ENABLE, 8'h00);
    push_host_frame({8'hA5, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hC3}, 1'b1, 1'b0);
    send_wire();
    wait_idle();
  endtask

  task automatic test_backpressure();
    int unsigned sent;
    logic [8:0] w;
    set_config(StartByteRst, OwnIdRst, HostIdRst, EscapeByteRst, EscapeMaskRst, 1'b1);
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    hold_off   <= 1'b1;
    fork
      begin
        repeat (200) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    sent = 0;
    while (sent < 40) begin
      if (wire_q.size() == 0) make_burst();
      w = wire_q.pop_front();
      send_byte(w[7:0], w[8]);
      sent++;
    end
    wire_q.delete();
    wait_idle();
  endtask

  // phase ends wherever the byte count runs out, often in the middle of a frame
  task automatic run_phase(input int unsigned n_bytes, input logic tx_idle, input logic rx_idle);
    int unsigned sent;
    logic [8:0] w;
    tx_idle_en <= tx_idle;
    rx_idle_en <= rx_idle;
    sent = 0;
    while (sent < n_bytes) begin
      if (wire_q.size() == 0) make_burst();
      w = wire_q.pop_front();
      send_byte(w[7:0], w[8]);
      sent++;
    end
    wire_q.delete();
    wait_idle();
  endtask

  task automatic test_random_settings();
    set_config(StartByteRst, OwnIdRst, HostIdRst, EscapeByteRst, EscapeMaskRst, 1'b1);
    run_phase(135, 1'b0, 1'b0);
    // own and host equal, everything but the start byte at the top
    set_config(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    run_phase(135, 1'b1, 1'b1);
    set_config(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    run_phase(135, 1'b1, 1'b0);
    set_config(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
               8'($urandom()), 1'($urandom()));
    run_phase(135, 1'b0, 1'b1);
    set_config(StartByteRst, OwnIdRst, OwnIdRst, EscapeByteRst, EscapeMaskRst, 1'b1);
    run_phase(135, 1'b1, 1'b1);
    set_config(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
               8'($urandom()), 1'($urandom()));
    run_phase(135, 1'($urandom()), 1'($urandom()));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_frame_and_polls();
    test_no_check_frame();
    test_backpressure();
    test_random_settings();
    wait_idle();
    if (mismatches == 0 && parse_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
